[hw/rtl/grwi_pkg.sv]
`default_nettype none
package grwi_pkg;

  // Default geometry
  localparam int TILE_PIXELS_DEF = 64;
  localparam int MAP_SIDE_DEF    = 64;

  // Field widths
  localparam int POS_W   = 20;
  localparam int ANG_W   = 12;
  localparam int COORD_W = 22;
  localparam int TAN_W   = 24;
  localparam int ROM_W   = 23;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 48;
  localparam int WIDE_W  = 34;
  localparam int DIST_W  = 48;
  localparam int CFG_W   = 7;
  localparam int ROW_W   = 6;

  // Fixed-point limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = 22'sh1FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -22'sh200000;
  localparam logic [ROM_W-1:0]          TAN_MAX   = 23'h7FFFFF;
  localparam longint unsigned           PI_Q30    = 64'd3373259426;

  // Angles in tenths of a degree
  localparam logic [12:0] ANG_90  = 13'd900;
  localparam logic [12:0] ANG_180 = 13'd1800;
  localparam logic [12:0] ANG_270 = 13'd2700;
  localparam logic [12:0] ANG_360 = 13'd3600;
  localparam int          ROM_DEPTH = 901;

  // Codes
  localparam logic       REQ_WRITE    = 1'b0;
  localparam logic       REQ_CAST     = 1'b1;
  localparam logic [0:0] CFG_MAP_COLS = 1'b0;
  localparam logic [0:0] CFG_MAP_ROWS = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROM_W-1:0] tan_tab_t [ROM_DEPTH];

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_ACCEPT, DP_SETUP1, DP_SETUP2, DP_SETUP3,
    DP_HSET1, DP_HSET2, DP_HSET3, DP_VSET1, DP_VSET2, DP_VSET3,
    DP_TCHK, DP_TDIV, DP_TSTEP, DP_HSAVE, DP_VSAVE,
    DP_SQ1, DP_SQ2, DP_SQ3, DP_SQ4, DP_SQ5, DP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP1, ST_SETUP2, ST_SETUP3,
    ST_HSET1, ST_HSET2, ST_HSET3, ST_VSET1, ST_VSET2, ST_VSET3,
    ST_CHK, ST_DIV, ST_WALL, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_SQ5, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   flag;   // wall bit for the save ops
  } dp_cmd_t;

  typedef struct packed {
    logic is_cast;
    logic h_on;
    logic v_on;
    logic in_map;
    logic at_limit;
    logic wall_hit;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

  // Saturate a wide signed value to a coordinate
  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(COORD_MAX)) return COORD_MAX;
    if (v < WIDE_W'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Unsigned quotient by shift and subtract, used at elaboration only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    logic [64:0]     rem;
    longint unsigned q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // First-quadrant tangent in Q7.16, evaluated at elaboration
  function automatic logic [ROM_W-1:0] tan_first(input int r);
    longint unsigned x, x2, ts, tc, q, dv;
    longint s, c;
    s = 0;
    c = 0;
    if (r >= 900) return TAN_MAX;
    x  = udiv64(longint'(r) * PI_Q30 + 64'd900, 64'd1800);
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    for (int k = 0; k < 12; k++) begin
      if ((k % 2) == 0) begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end else begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end
      dv = longint'((2 * k + 2) * (2 * k + 3));
      ts = udiv64((ts * x2) >> 30, dv);
      dv = longint'((2 * k + 1) * (2 * k + 2));
      tc = udiv64((tc * x2) >> 30, dv);
    end
    if (c <= 0) return TAN_MAX;
    if (s < 0) s = 0;
    q = udiv64((longint'(s) << 16) + (longint'(c) >> 1), longint'(c));
    if (q > longint'(TAN_MAX)) return TAN_MAX;
    return q[ROM_W-1:0];
  endfunction

  function automatic tan_tab_t build_tan_tab();
    tan_tab_t t;
    for (int i = 0; i < ROM_DEPTH; i++) t[i] = tan_first(i);
    return t;
  endfunction

  localparam tan_tab_t TAN_TAB = build_tan_tab();

endpackage
`default_nettype wire

[hw/rtl/grwi_datapath.sv]
`default_nettype none
module grwi_datapath #(
  parameter int TILE_PIXELS = grwi_pkg::TILE_PIXELS_DEF,
  parameter int MAP_SIDE    = grwi_pkg::MAP_SIDE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  grwi_pkg::dp_cmd_t                cmd_i,
  output grwi_pkg::dp_stat_t               stat_o,
  input  wire                              req_type_i,
  input  wire  [grwi_pkg::ROW_W-1:0]       cell_row_i,
  input  wire  [grwi_pkg::ROW_W-1:0]       cell_col_i,
  input  wire                              cell_is_wall_i,
  input  wire  [grwi_pkg::POS_W-1:0]       player_x_i,
  input  wire  [grwi_pkg::POS_W-1:0]       player_y_i,
  input  wire  [grwi_pkg::ANG_W-1:0]       cast_angle_i,
  input  wire                              cfg_we_i,
  input  wire  [0:0]                       cfg_index_i,
  input  wire  [grwi_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [grwi_pkg::COORD_W-1:0] hit_x_o,
  output logic signed [grwi_pkg::COORD_W-1:0] hit_y_o,
  output logic                             hit_side_o,
  output logic                             wall_found_o
);
  import grwi_pkg::*;

  localparam int TILE_FX = TILE_PIXELS * 256;
  localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
  localparam int AW      = $clog2(DEPTH);
  localparam int LIMIT   = MAP_SIDE + 2;
  localparam int NW      = $clog2(LIMIT + 1);
  localparam int RECIP   = (1 << 14) / TILE_PIXELS;
  localparam int EW      = $clog2(MAP_SIDE + 1);
  localparam int DW      = $clog2(MAP_SIDE * TILE_FX + 1);
  localparam int CMPW    = ((DW > 21) ? DW : 21) + 1;
  localparam int PXW     = 13;

  // Configuration and derived map extent
  logic [CFG_W-1:0] cols_q, rows_q;
  logic [DW-1:0]    w_q, h_q;
  logic [EW-1:0]    eff_cols, eff_rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_W'(64);
      rows_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAP_COLS: cols_q <= cfg_data_i;
        CFG_MAP_ROWS: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_cols = (32'(cols_q) > MAP_SIDE) ? EW'(MAP_SIDE) : EW'(cols_q);
    eff_rows = (32'(rows_q) > MAP_SIDE) ? EW'(MAP_SIDE) : EW'(rows_q);
  end

  always_ff @(posedge clk_i) begin
    w_q <= DW'(32'(eff_cols) * TILE_FX);
    h_q <= DW'(32'(eff_rows) * TILE_FX);
  end

  // Working registers
  logic [POS_W-1:0]  px_q, py_q;
  logic [ANG_W-1:0]  a_q;
  coord_t            x_q, y_q, stepx_q, stepy_q, lft_q, top_q;
  coord_t            hx_q, hy_q, vx_q, vy_q;
  logic              hw_q, vw_q;
  logic signed [TAN_W-1:0]  cot_q, tan_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DIST_W-1:0] dh_q, dv_q;
  logic [PXW-1:0]    q0x_q, q0y_q, colc, rowc;
  logic [NW-1:0]     n_q;
  logic [AW-1:0]     clr_q;
  logic [ROM_W-1:0]  rom_q;
  logic              rom_neg_q, rd_q;

  // Angle flags
  logic up, left, h_on, v_on;
  always_comb begin
    up   = (a_q != '0) && (13'(a_q) < ANG_180);
    left = (13'(a_q) > ANG_90) && (13'(a_q) < ANG_270);
    h_on = (a_q != '0) && (13'(a_q) != ANG_180);
    v_on = (13'(a_q) != ANG_90) && (13'(a_q) != ANG_270);
  end

  // Tangent ROM addressing: fold into the first quadrant
  logic [12:0] ca, cr, tr, cidx, tidx, ridx;
  logic        cneg, tneg, rneg;
  always_comb begin
    ca   = 13'd4500 - 13'(a_q);
    if (ca >= ANG_360) ca = ca - ANG_360;
    cr   = (ca >= ANG_180) ? ca - ANG_180 : ca;
    cneg = cr > ANG_90;
    cidx = cneg ? ANG_180 - cr : cr;
    tr   = (13'(a_q) >= ANG_180) ? 13'(a_q) - ANG_180 : 13'(a_q);
    tneg = tr > ANG_90;
    tidx = tneg ? ANG_180 - tr : tr;
    ridx = (cmd_i.op == DP_SETUP1) ? cidx : tidx;
    rneg = (cmd_i.op == DP_SETUP1) ? cneg : tneg;
  end

  always_ff @(posedge clk_i) begin
    rom_q     <= TAN_TAB[ridx[9:0]];
    rom_neg_q <= rneg;
  end

  logic signed [TAN_W-1:0] rom_val;
  assign rom_val = rom_neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  // Tile index: reciprocal multiply, then one correction
  logic [PXW-1:0] pix_x, pix_y;
  logic [21:0]    rem_x, rem_y;
  assign pix_x = x_q[20:8];
  assign pix_y = y_q[20:8];
  always_comb begin
    rem_x = 22'(pix_x) - 22'(q0x_q) * 22'(TILE_PIXELS);
    rem_y = 22'(pix_y) - 22'(q0y_q) * 22'(TILE_PIXELS);
    colc  = q0x_q + PXW'(rem_x >= 22'(TILE_PIXELS));
    rowc  = q0y_q + PXW'(rem_y >= 22'(TILE_PIXELS));
  end

  // Setup start points
  coord_t hy_c, vx_c, tile_pos, tile_neg;
  always_comb begin
    tile_pos = COORD_W'(TILE_FX);
    tile_neg = -COORD_W'(TILE_FX);
    hy_c = up ? sat_coord(WIDE_W'(top_q) - WIDE_W'(256))
              : sat_coord(WIDE_W'(top_q) + WIDE_W'(TILE_FX));
    vx_c = left ? sat_coord(WIDE_W'(lft_q) - WIDE_W'(256))
                : sat_coord(WIDE_W'(lft_q) + WIDE_W'(TILE_FX));
  end

  // Shared multiplier operands
  logic signed [MUL_W-1:0] mul_a, mul_b, spx, spy;
  assign spx = $signed(MUL_W'({1'b0, px_q}));
  assign spy = $signed(MUL_W'({1'b0, py_q}));
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      DP_HSET1: begin mul_a = spy - MUL_W'(hy_c); mul_b = cot_q; end
      DP_HSET2: begin mul_a = up ? MUL_W'(tile_pos) : MUL_W'(tile_neg); mul_b = cot_q; end
      DP_VSET1: begin mul_a = spx - MUL_W'(vx_c); mul_b = tan_q; end
      DP_VSET2: begin mul_a = left ? MUL_W'(tile_pos) : MUL_W'(tile_neg); mul_b = tan_q; end
      DP_SQ1:   begin mul_a = MUL_W'(hx_q) - spx; mul_b = mul_a; end
      DP_SQ2:   begin mul_a = MUL_W'(hy_q) - spy; mul_b = mul_a; end
      DP_SQ3:   begin mul_a = MUL_W'(vx_q) - spx; mul_b = mul_a; end
      DP_SQ4:   begin mul_a = MUL_W'(vy_q) - spy; mul_b = mul_a; end
      default: ;
    endcase
  end

  // Round the product back to Q13.8
  logic signed [PROD_W-1:0] prod_b;
  logic signed [31:0]       rnd;
  assign prod_b = prod_q + PROD_W'(32768);
  assign rnd    = prod_b[PROD_W-1:16];

  logic pick_v;
  always_comb begin
    if (!h_on)      pick_v = 1'b1;
    else if (!v_on) pick_v = 1'b0;
    else            pick_v = !(dh_q < dv_q);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_ACCEPT: begin
        px_q <= player_x_i;
        py_q <= player_y_i;
        x_q  <= $signed(COORD_W'(player_x_i));
        y_q  <= $signed(COORD_W'(player_y_i));
        a_q  <= (13'(cast_angle_i) >= ANG_360) ? ANG_W'(13'(cast_angle_i) - ANG_360)
                                               : cast_angle_i;
      end
      DP_SETUP1, DP_TCHK: begin
        q0x_q <= PXW'((27'(pix_x) * 27'(RECIP)) >> 14);
        q0y_q <= PXW'((27'(pix_y) * 27'(RECIP)) >> 14);
      end
      DP_SETUP2: begin
        q0x_q <= colc;
        q0y_q <= rowc;
        cot_q <= rom_val;
      end
      DP_SETUP3: begin
        tan_q <= rom_val;
        lft_q <= COORD_W'(32'(q0x_q) * TILE_FX);
        top_q <= COORD_W'(32'(q0y_q) * TILE_FX);
      end
      DP_HSET1: begin
        y_q    <= hy_c;
        prod_q <= mul_a * mul_b;
      end
      DP_HSET2: begin
        x_q    <= sat_coord($signed(WIDE_W'({1'b0, px_q})) + WIDE_W'(rnd));
        prod_q <= mul_a * mul_b;
      end
      DP_HSET3: begin
        stepx_q <= sat_coord(WIDE_W'(rnd));
        stepy_q <= up ? tile_neg : tile_pos;
      end
      DP_VSET1: begin
        x_q    <= vx_c;
        prod_q <= mul_a * mul_b;
      end
      DP_VSET2: begin
        y_q    <= sat_coord($signed(WIDE_W'({1'b0, py_q})) + WIDE_W'(rnd));
        prod_q <= mul_a * mul_b;
      end
      DP_VSET3: begin
        stepy_q <= sat_coord(WIDE_W'(rnd));
        stepx_q <= left ? tile_neg : tile_pos;
      end
      DP_TSTEP: begin
        x_q <= sat_coord(WIDE_W'(x_q) + WIDE_W'(stepx_q));
        y_q <= sat_coord(WIDE_W'(y_q) + WIDE_W'(stepy_q));
      end
      DP_HSAVE: begin hx_q <= x_q; hy_q <= y_q; hw_q <= cmd_i.flag; end
      DP_VSAVE: begin vx_q <= x_q; vy_q <= y_q; vw_q <= cmd_i.flag; end
      DP_SQ1:   prod_q <= mul_a * mul_b;
      DP_SQ2:   begin dh_q <= DIST_W'(prod_q); prod_q <= mul_a * mul_b; end
      DP_SQ3:   begin dh_q <= dh_q + DIST_W'(prod_q); prod_q <= mul_a * mul_b; end
      DP_SQ4:   begin dv_q <= DIST_W'(prod_q); prod_q <= mul_a * mul_b; end
      DP_SQ5:   dv_q <= dv_q + DIST_W'(prod_q);
      DP_OUT: begin
        hit_x_o      <= pick_v ? vx_q : hx_q;
        hit_y_o      <= pick_v ? vy_q : hy_q;
        hit_side_o   <= pick_v;
        wall_found_o <= pick_v ? vw_q : hw_q;
      end
      default: ;
    endcase
  end

  // Probe counter and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.op == DP_HSET3 || cmd_i.op == DP_VSET3) n_q <= '0;
      else if (cmd_i.op == DP_TSTEP) n_q <= n_q + 1'b1;
      if (cmd_i.op == DP_CLEAR) clr_q <= clr_q + 1'b1;
      if (cmd_i.op == DP_OUT) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // Wall map: one write port, one registered read port
  logic          wall_mem [DEPTH];
  logic          mem_we, mem_wd;
  logic [AW-1:0] mem_wa, mem_ra;
  always_comb begin
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = clr_q;
    if (cmd_i.op == DP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd_i.op == DP_ACCEPT && req_type_i == REQ_WRITE &&
                 32'(cell_row_i) < MAP_SIDE && 32'(cell_col_i) < MAP_SIDE) begin
      mem_we = 1'b1;
      mem_wd = cell_is_wall_i;
      mem_wa = AW'(32'(cell_row_i) * MAP_SIDE + 32'(cell_col_i));
    end
    mem_ra = AW'(32'(rowc) * MAP_SIDE + 32'(colc));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) wall_mem[mem_wa] <= mem_wd;
    if (cmd_i.op == DP_TDIV) rd_q <= wall_mem[mem_ra];
  end

  // Status
  always_comb begin
    stat_o.is_cast  = (req_type_i == REQ_CAST);
    stat_o.h_on     = h_on;
    stat_o.v_on     = v_on;
    stat_o.in_map   = !x_q[COORD_W-1] && !y_q[COORD_W-1] &&
                      (CMPW'(x_q[20:0]) < CMPW'(w_q)) && (CMPW'(y_q[20:0]) < CMPW'(h_q));
    stat_o.at_limit = (n_q == NW'(LIMIT));
    stat_o.wall_hit = rd_q;
    stat_o.clr_last = (clr_q == AW'(DEPTH - 1));
    stat_o.out_busy = out_valid_o && out_stall_i;
  end

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(LIMIT)) else $error("probe count past limit");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_OUT) |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");
  a_side_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_OUT && !h_on) |=> hit_side_o)
    else $error("horizontal side chosen with horizontal search off");
  a_side_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_OUT && !v_on) |=> !hit_side_o)
    else $error("vertical side chosen with vertical search off");

endmodule
`default_nettype wire

[hw/rtl/grwi_ctrl.sv]
`default_nettype none
module grwi_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  grwi_pkg::dp_stat_t  stat_i,
  output grwi_pkg::dp_cmd_t   cmd_o
);
  import grwi_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        dir_q, dir_d;   // 0 horizontal search, 1 vertical search
  ctrl_state_e after_save;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  always_comb begin
    if (!dir_q) after_save = stat_i.v_on ? ST_VSET1 : ST_OUT;
    else        after_save = stat_i.h_on ? ST_SQ1 : ST_OUT;
  end

  always_comb begin
    state_d    = state_q;
    dir_d      = dir_q;
    in_stall_o = 1'b1;
    cmd_o.op   = DP_NOP;
    cmd_o.flag = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          if (stat_i.is_cast) state_d = ST_SETUP1;
        end
      end
      ST_SETUP1: begin cmd_o.op = DP_SETUP1; state_d = ST_SETUP2; end
      ST_SETUP2: begin cmd_o.op = DP_SETUP2; state_d = ST_SETUP3; end
      ST_SETUP3: begin
        cmd_o.op = DP_SETUP3;
        state_d  = stat_i.h_on ? ST_HSET1 : ST_VSET1;
      end
      ST_HSET1: begin cmd_o.op = DP_HSET1; state_d = ST_HSET2; end
      ST_HSET2: begin cmd_o.op = DP_HSET2; state_d = ST_HSET3; end
      ST_HSET3: begin cmd_o.op = DP_HSET3; dir_d = 1'b0; state_d = ST_CHK; end
      ST_VSET1: begin cmd_o.op = DP_VSET1; state_d = ST_VSET2; end
      ST_VSET2: begin cmd_o.op = DP_VSET2; state_d = ST_VSET3; end
      ST_VSET3: begin cmd_o.op = DP_VSET3; dir_d = 1'b1; state_d = ST_CHK; end
      // probe: bounds, tile lookup, wall test
      ST_CHK: begin
        if (stat_i.at_limit || !stat_i.in_map) begin
          cmd_o.op = dir_q ? DP_VSAVE : DP_HSAVE;
          state_d  = after_save;
        end else begin
          cmd_o.op = DP_TCHK;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin cmd_o.op = DP_TDIV; state_d = ST_WALL; end
      ST_WALL: begin
        if (stat_i.wall_hit) begin
          cmd_o.op   = dir_q ? DP_VSAVE : DP_HSAVE;
          cmd_o.flag = 1'b1;
          state_d    = after_save;
        end else begin
          cmd_o.op = DP_TSTEP;
          state_d  = ST_CHK;
        end
      end
      ST_SQ1: begin cmd_o.op = DP_SQ1; state_d = ST_SQ2; end
      ST_SQ2: begin cmd_o.op = DP_SQ2; state_d = ST_SQ3; end
      ST_SQ3: begin cmd_o.op = DP_SQ3; state_d = ST_SQ4; end
      ST_SQ4: begin cmd_o.op = DP_SQ4; state_d = ST_SQ5; end
      ST_SQ5: begin cmd_o.op = DP_SQ5; state_d = ST_OUT; end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o) else $error("input taken during clear");
  a_hit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALL && stat_i.wall_hit) |=> (state_q != ST_CHK))
    else $error("search kept stepping after a wall");

endmodule
`default_nettype wire

[hw/rtl/grid_ray_wall_intersection_unit.sv]
// Cell write: taken when accepted, no result beat. Cast: accepted, then SETUP1 to SETUP3;
// then per active search SET1 to SET3 for the start point, CHK, DIV and WALL per probe that
// steps on (one map lookup each), and CHK to close on leaving the map or the step limit (WALL
// on a wall); SQ1 to SQ5 compare distances when both searches run; OUT loads the result.
// One item in flight; the result register frees the input while a beat waits downstream.
// Reset: asynchronous; clearing all MAP_SIDE*MAP_SIDE cells stalls input, config taken.
`default_nettype none
module grid_ray_wall_intersection_unit #(
  parameter int TILE_PIXELS = grwi_pkg::TILE_PIXELS_DEF,
  parameter int MAP_SIDE    = grwi_pkg::MAP_SIDE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              req_type_i,
  input  wire  [grwi_pkg::ROW_W-1:0]       cell_row_i,
  input  wire  [grwi_pkg::ROW_W-1:0]       cell_col_i,
  input  wire                              cell_is_wall_i,
  input  wire  [grwi_pkg::POS_W-1:0]       player_x_i,
  input  wire  [grwi_pkg::POS_W-1:0]       player_y_i,
  input  wire  [grwi_pkg::ANG_W-1:0]       cast_angle_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [grwi_pkg::COORD_W-1:0] hit_x_o,
  output logic signed [grwi_pkg::COORD_W-1:0] hit_y_o,
  output logic                             hit_side_o,
  output logic                             wall_found_o,
  input  wire                              cfg_we_i,
  input  wire  [0:0]                       cfg_index_i,
  input  wire  [grwi_pkg::CFG_W-1:0]       cfg_data_i
);
  import grwi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  grwi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  grwi_datapath #(
    .TILE_PIXELS (TILE_PIXELS),
    .MAP_SIDE    (MAP_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .cell_is_wall_i (cell_is_wall_i),
    .player_x_i     (player_x_i),
    .player_y_i     (player_y_i),
    .cast_angle_i   (cast_angle_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o),
    .hit_side_o     (hit_side_o),
    .wall_found_o   (wall_found_o)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import grwi_pkg::*;

  localparam int TILE_Q     = 64 * 256;  // one tile in Q13.8
  localparam int SIDE       = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYC   = 1500;
  localparam int SETTLE_CYC = 600;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      side;
    logic                      wall;
  } hit_t;

  // Ray-cast predictor plus queue of pending hit beats
  class hit_scoreboard;
    bit     wall_bits [SIDE*SIDE];
    int     cols;
    int     rows;
    longint tan_q [0:900];
    hit_t   pending_hits [$];
    int     errors;

    function new();
      longint unsigned xr, x2, ts, tc, q;
      longint sn, cs;
      cols   = 64;
      rows   = 64;
      errors = 0;
      foreach (wall_bits[i]) wall_bits[i] = 0;
      // first-quadrant tangent table, Q7.16
      for (int r = 0; r <= 900; r++) begin
        if (r == 900) begin
          tan_q[r] = TAN_MAX;
          continue;
        end
        xr = (longint'(r) * PI_Q30 + 64'd900) / 64'd1800;
        x2 = (xr * xr) >> 30;
        ts = xr;
        tc = 64'd1 << 30;
        sn = 0;
        cs = 0;
        for (int k = 0; k < 12; k++) begin
          if (k % 2 == 0) begin
            sn += longint'(ts);
            cs += longint'(tc);
          end else begin
            sn -= longint'(ts);
            cs -= longint'(tc);
          end
          ts = ((ts * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
          tc = ((tc * x2) >> 30) / 64'((2 * k + 1) * (2 * k + 2));
        end
        if (cs <= 0) tan_q[r] = TAN_MAX;
        else begin
          if (sn < 0) sn = 0;
          q = ((64'(sn) << 16) + 64'(cs) / 2) / 64'(cs);
          tan_q[r] = (q > 64'(TAN_MAX)) ? longint'(TAN_MAX) : longint'(q);
        end
      end
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    function longint clamp(longint v);
      if (v > 2097151) return 2097151;
      if (v < -2097152) return -2097152;
      return v;
    endfunction

    function longint tangent(int ang);
      int r;
      r = (ang % 3600) % 1800;
      if (r > 900) return -tan_q[1800 - r];
      return tan_q[r];
    endfunction

    function longint scale(longint v, longint t);
      return (v * t + 32768) >>> 16;
    endfunction

    function bit on_map(longint x, longint y);
      longint w, h;
      w = longint'(cols > SIDE ? SIDE : cols) * TILE_Q;
      h = longint'(rows > SIDE ? SIDE : rows) * TILE_Q;
      return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // step along grid lines until a wall, the map edge or the step limit
    function bit march(inout longint x, inout longint y, input longint sx, input longint sy);
      int c, r;
      for (int n = 0; n < SIDE + 2; n++) begin
        if (!on_map(x, y)) return 0;
        c = int'((x >> 8) / 64);
        r = int'((y >> 8) / 64);
        if (c < SIDE && r < SIDE && wall_bits[r*SIDE + c]) return 1;
        x = clamp(x + sx);
        y = clamp(y + sy);
      end
      return 0;
    endfunction

    function void set_reg(logic [0:0] idx, int val);
      if (idx == CFG_MAP_COLS) cols = val;
      else rows = val;
    endfunction

    // note an accepted input beat
    function void note_input(logic rt, int row, int col, logic wall,
                             longint px, longint py, int ang_in);
      longint hx, hy, vx, vy, edge0, sx, sy, t, dh, dv;
      bit h_on, v_on, hw, vw, up, lft, pick_v;
      int a;
      hit_t e;
      if (rt == REQ_WRITE) begin
        wall_bits[row*SIDE + col] = wall;
        return;
      end
      hx = 0; hy = 0; vx = 0; vy = 0; hw = 0; vw = 0;
      a = ang_in % 3600;
      h_on = (a != 0 && a != 1800);
      v_on = (a != 900 && a != 2700);
      if (h_on) begin
        t     = tangent(900 + 3600 - a);
        up    = (a > 0 && a < 1800);
        edge0 = ((py >> 8) / 64) * TILE_Q;
        sy    = up ? -TILE_Q : TILE_Q;
        hy    = clamp(up ? edge0 - 256 : edge0 + TILE_Q);
        hx    = clamp(px + scale(py - hy, t));
        hw    = march(hx, hy, clamp(scale(-sy, t)), sy);
      end
      if (v_on) begin
        t     = tangent(a);
        lft   = (a > 900 && a < 2700);
        edge0 = ((px >> 8) / 64) * TILE_Q;
        sx    = lft ? -TILE_Q : TILE_Q;
        vx    = clamp(lft ? edge0 - 256 : edge0 + TILE_Q);
        vy    = clamp(py + scale(px - vx, t));
        vw    = march(vx, vy, sx, clamp(scale(-sx, t)));
      end
      dh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
      dv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
      if (!h_on) pick_v = 1;
      else if (!v_on) pick_v = 0;
      else pick_v = !(dh < dv);
      e.x    = pick_v ? vx[COORD_W-1:0] : hx[COORD_W-1:0];
      e.y    = pick_v ? vy[COORD_W-1:0] : hy[COORD_W-1:0];
      e.side = pick_v;
      e.wall = pick_v ? vw : hw;
      pending_hits.push_back(e);
    endfunction

    // compare one hit beat with the oldest prediction
    function void check_hit(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic side, logic wall);
      hit_t e;
      if (pending_hits.size() == 0) begin
        $error("unexpected hit beat x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (x !== e.x) begin
        $error("hit_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("hit_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
      if (side !== e.side) begin
        $error("hit_side: expected %0d, got %0d", e.side, side);
        errors++;
      end
      if (wall !== e.wall) begin
        $error("wall_found: expected %0d, got %0d", e.wall, wall);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, req_type, cell_is_wall;
  logic [ROW_W-1:0] cell_row, cell_col;
  logic [POS_W-1:0] player_x, player_y;
  logic [ANG_W-1:0] cast_angle;
  logic out_valid, out_stall, hit_side, wall_found;
  logic signed [COORD_W-1:0] hit_x, hit_y;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  hit_scoreboard sb;
  int  tx_gap_max, rx_gap_max, idle_cnt;
  bit  hold_req;

  grid_ray_wall_intersection_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .cell_row_i(cell_row), .cell_col_i(cell_col),
    .cell_is_wall_i(cell_is_wall), .player_x_i(player_x), .player_y_i(player_y),
    .cast_angle_i(cast_angle),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_x_o(hit_x), .hit_y_o(hit_y), .hit_side_o(hit_side), .wall_found_o(wall_found),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, with an occasional long hold-off
  initial begin : rx_proc
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 0;
      end
      n = $urandom_range(0, rx_gap_max);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_hit(hit_x, hit_y, hit_side, wall_found);
  end

  // watchdog: cycles without any beat or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic rt, input int row, input int col, input logic wall,
                           input int px, input int py, input int ang);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type     = rt;
    cell_row     = row[ROW_W-1:0];
    cell_col     = col[ROW_W-1:0];
    cell_is_wall = wall;
    player_x     = px[POS_W-1:0];
    player_y     = py[POS_W-1:0];
    cast_angle   = ang[ANG_W-1:0];
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(rt, row, col, wall, longint'(px), longint'(py), ang);
  endtask

  task automatic put_cell(input int row, input int col, input logic wall);
    send_beat(REQ_WRITE, row, col, wall, $urandom_range(0, 1048575),
              $urandom_range(0, 1048575), $urandom_range(0, 4095));
  endtask

  task automatic cast(input int px, input int py, input int ang);
    send_beat(REQ_CAST, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
              px, py, ang);
  endtask

  // drain, let the block settle, then write both size registers
  task automatic set_map_size(input int cols, input int rows);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_MAP_COLS;
    cfg_data  = cols[CFG_W-1:0];
    @(negedge clk);
    cfg_index = CFG_MAP_ROWS;
    cfg_data  = rows[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(CFG_MAP_COLS, cols);
    sb.set_reg(CFG_MAP_ROWS, rows);
  endtask

  // one random phase: seed the map, then mostly casts from inside it
  task automatic run_phase(input int n_items, input bit with_hold);
    int w, h, px, py, ang, pick;
    int special_angles [6] = '{0, 900, 1800, 2700, 3599, 4095};
    w = (sb.cols > SIDE ? SIDE : sb.cols) * TILE_Q;
    h = (sb.rows > SIDE ? SIDE : sb.rows) * TILE_Q;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      if (with_hold && i == n_items / 2) hold_req = 1;
      pick = $urandom_range(0, 99);
      if (i < 40 || pick < 20) begin
        put_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 9) < 3);
      end else begin
        if (pick < 88 && w > 0 && h > 0) begin
          px = $urandom_range(0, w - 1);
          py = $urandom_range(0, h - 1);
        end else begin
          px = $urandom_range(0, 1048575);
          py = $urandom_range(0, 1048575);
        end
        ang = (pick > 92) ? special_angles[$urandom_range(0, 5)] : $urandom_range(0, 4095);
        cast(px, py, ang);
      end
    end
  endtask

  initial begin : main
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    cell_row = '0;
    cell_col = '0;
    cell_is_wall = 1'b0;
    player_x = '0;
    player_y = '0;
    cast_angle = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAP_COLS;
    cfg_data = '0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    idle_cnt = 0;
    hold_req = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: corner walls, overwrite, cardinal and wrap-around angles
    tx_gap_max = 3;
    rx_gap_max = 3;
    put_cell(0, 0, 1);
    put_cell(63, 63, 1);
    put_cell(5, 7, 1);
    put_cell(5, 7, 0);
    put_cell(10, 12, 1);
    cast(0, 0, 0);
    cast(100 * 256, 100 * 256, 900);
    cast(100 * 256, 100 * 256, 1800);
    cast(100 * 256, 100 * 256, 2700);
    cast(700 * 256, 650 * 256, 450);
    cast(700 * 256, 650 * 256, 2250);
    cast(700 * 256, 650 * 256, 1);
    cast(700 * 256, 650 * 256, 899);
    cast(700 * 256, 650 * 256, 901);
    cast(700 * 256, 650 * 256, 3599);
    cast(700 * 256, 650 * 256, 4095);
    cast(1048575, 1048575, 1350);
    cast(0, 1048575, 3150);
    cast(64 * 256, 64 * 256, 1799);
    cast(4095 * 256 + 255, 30 * 256, 1801);
    cast(32 * 256, 32 * 256, 2701);

    run_phase(280, 1'b1);
    set_map_size(127, 100);
    run_phase(280, 1'b0);
    set_map_size(0, 5);
    run_phase(200, 1'b0);
    set_map_size(1, 1);
    run_phase(280, 1'b0);
    set_map_size(13, 40);
    run_phase(280, 1'b1);
    set_map_size(64, 64);
    run_phase(360, 1'b0);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
